FILE: src/cubic_bezier_forward_difference_top_defines.svh
// Assertion macros for the cubic Bezier forward-difference generator.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef CUBIC_BEZIER_FORWARD_DIFFERENCE_TOP_DEFINES_SVH
`define CUBIC_BEZIER_FORWARD_DIFFERENCE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CBFD_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("cbfd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CBFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("cbfd assertion failed");

`endif

FILE: src/cbfd_pkg.sv
// Package for the cubic Bezier forward-difference generator.
// Holds the widths, register indexes and shared types; depends on nothing.
package cbfd_pkg;

    localparam int STEP_SHIFT = 10;
    localparam int FRAC_BITS  = 3 * STEP_SHIFT;
    localparam int STATE_W    = 48;
    localparam int PT_W       = 11;
    localparam int COEF_W     = 18;
    localparam int CNT_W      = STEP_SHIFT + 2;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CNT_W-1:0] LAST_INDEX = CNT_W'(1) << STEP_SHIFT;
    localparam logic [CNT_W-1:0] PAST_MARK  = LAST_INDEX + CNT_W'(1);

    localparam logic [CFG_IDX_W-1:0] REG_START_X    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_START_Y    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_PULL_ONE_X = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_PULL_ONE_Y = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_PULL_TWO_X = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_PULL_TWO_Y = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_END_X      = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] REG_END_Y      = CFG_IDX_W'(7);

    typedef logic signed [PT_W-1:0]    t_point;
    typedef logic signed [COEF_W-1:0]  t_coef;
    typedef logic signed [STATE_W-1:0] t_state;

    typedef struct packed {
        t_point p0;
        t_point p1;
        t_point p2;
        t_point p3;
    } t_ctrl_pts;

    typedef struct packed {
        logic load;
        logic advance;
    } t_axis_ctrl;

endpackage

FILE: src/cbfd_cfg_regs.sv
// Control-point register file of the cubic Bezier forward-difference generator.
// Uses cbfd_pkg for register indexes and the control-point struct.
module cbfd_cfg_regs
    import cbfd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [PT_W-1:0]      i_cfg_data,
    output t_ctrl_pts            o_pts_x,
    output t_ctrl_pts            o_pts_y
);

    t_ctrl_pts r_pts_x;
    t_ctrl_pts r_pts_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pts_x <= '0;
            r_pts_y <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_START_X:    r_pts_x.p0 <= i_cfg_data;
                REG_START_Y:    r_pts_y.p0 <= i_cfg_data;
                REG_PULL_ONE_X: r_pts_x.p1 <= i_cfg_data;
                REG_PULL_ONE_Y: r_pts_y.p1 <= i_cfg_data;
                REG_PULL_TWO_X: r_pts_x.p2 <= i_cfg_data;
                REG_PULL_TWO_Y: r_pts_y.p2 <= i_cfg_data;
                REG_END_X:      r_pts_x.p3 <= i_cfg_data;
                REG_END_Y:      r_pts_y.p3 <= i_cfg_data;
                default: begin
                    r_pts_x <= r_pts_x;
                end
            endcase
        end
    end

    assign o_pts_x = r_pts_x;
    assign o_pts_y = r_pts_y;

endmodule

FILE: src/cbfd_axis.sv
// One axis of the forward-difference engine: coefficient load, difference
// registers, one-step advance and rounding of the next value. Uses cbfd_pkg.
module cbfd_axis
    import cbfd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_axis_ctrl i_ctrl,
    input  t_ctrl_pts  i_pts,
    output t_point     o_point
);

    t_state r_val;
    t_state r_d1;
    t_state r_d2;
    t_state r_d3;
    t_state n_val;
    t_state n_d1;
    t_state n_d2;
    t_state n_d3;

    t_coef w_p0;
    t_coef w_p1;
    t_coef w_p2;
    t_coef w_p3;
    t_coef w_p1m2;
    t_coef w_b_half;
    t_coef w_p1m0;
    t_coef w_a;
    t_coef w_b;
    t_coef w_c;
    t_coef w_a6;
    t_coef w_b2;
    t_state w_ld_val;
    t_state w_ld_d1;
    t_state w_ld_d2;
    t_state w_ld_d3;

    always_comb begin
        w_p0     = COEF_W'(i_pts.p0);
        w_p1     = COEF_W'(i_pts.p1);
        w_p2     = COEF_W'(i_pts.p2);
        w_p3     = COEF_W'(i_pts.p3);
        w_p1m2   = w_p1 - w_p2;
        w_b_half = w_p0 + w_p2 - (w_p1 <<< 1);
        w_p1m0   = w_p1 - w_p0;
        w_a      = w_p3 - w_p0 + (w_p1m2 <<< 1) + w_p1m2;
        w_b      = (w_b_half <<< 1) + w_b_half;
        w_c      = (w_p1m0 <<< 1) + w_p1m0;
        w_a6     = (w_a <<< 2) + (w_a <<< 1);
        w_b2     = w_b <<< 1;

        w_ld_val = STATE_W'(i_pts.p0) <<< FRAC_BITS;
        w_ld_d1  = (STATE_W'(w_c) <<< (2 * STEP_SHIFT)) + (STATE_W'(w_b) <<< STEP_SHIFT)
                   + STATE_W'(w_a);
        w_ld_d2  = (STATE_W'(w_b2) <<< STEP_SHIFT) + STATE_W'(w_a6);
        w_ld_d3  = STATE_W'(w_a6);
    end

    always_comb begin
        if (i_ctrl.load) begin
            n_val = w_ld_val;
            n_d1  = w_ld_d1;
            n_d2  = w_ld_d2;
            n_d3  = w_ld_d3;
        end else if (i_ctrl.advance) begin
            n_val = r_val + r_d1;
            n_d1  = r_d1 + r_d2;
            n_d2  = r_d2 + r_d3;
            n_d3  = r_d3;
        end else begin
            n_val = r_val;
            n_d1  = r_d1;
            n_d2  = r_d2;
            n_d3  = r_d3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val <= '0;
            r_d1  <= '0;
            r_d2  <= '0;
            r_d3  <= '0;
        end else begin
            r_val <= n_val;
            r_d1  <= n_d1;
            r_d2  <= n_d2;
            r_d3  <= n_d3;
        end
    end

    // Round half up: integer bits plus the first fraction bit.
    assign o_point = n_val[FRAC_BITS +: PT_W] + PT_W'(n_val[FRAC_BITS-1]);

endmodule

FILE: src/cubic_bezier_forward_difference_top.sv
// A result word is registered and presented in the cycle after its input word is accepted.
// Throughput: one word per cycle; the input side stalls only while the output
// register holds a word that is not taken. The three additions per axis set the pace.
// Reset clears the control points and difference state; a step before any restart
// reports past end.
module cubic_bezier_forward_difference_top
    import cbfd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [PT_W-1:0]      i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_restart,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic signed [PT_W-1:0] o_point_x,
    output logic signed [PT_W-1:0] o_point_y,
    output logic                 o_is_last,
    output logic                 o_past_end
);

`include "cubic_bezier_forward_difference_top_defines.svh"

    t_ctrl_pts  w_pts_x;
    t_ctrl_pts  w_pts_y;
    t_axis_ctrl w_ctrl;
    t_point     w_point_x;
    t_point     w_point_y;
    logic       w_accept;
    logic       w_step_ok;
    logic [CNT_W-1:0] w_cnt_inc;

    logic [CNT_W-1:0] r_step_cnt;
    logic [CNT_W-1:0] n_step_cnt;
    logic             r_out_valid;
    t_point           r_point_x;
    t_point           r_point_y;
    logic             r_is_last;
    logic             r_past_end;

    cbfd_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_pts_x    (w_pts_x),
        .o_pts_y    (w_pts_y)
    );

    cbfd_axis u_axis_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .i_pts   (w_pts_x),
        .o_point (w_point_x)
    );

    cbfd_axis u_axis_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .i_pts   (w_pts_y),
        .o_point (w_point_y)
    );

    assign o_in_ready     = !r_out_valid || i_out_ready;
    assign w_accept       = i_in_valid && o_in_ready;
    assign w_step_ok      = r_step_cnt < LAST_INDEX;
    assign w_cnt_inc      = r_step_cnt + CNT_W'(1);
    assign w_ctrl.load    = w_accept && i_restart;
    assign w_ctrl.advance = w_accept && !i_restart && w_step_ok;

    always_comb begin
        if (i_restart) begin
            n_step_cnt = '0;
        end else if (w_step_ok) begin
            n_step_cnt = w_cnt_inc;
        end else begin
            n_step_cnt = r_step_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_cnt  <= PAST_MARK;
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_step_cnt  <= n_step_cnt;
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            if (!i_restart && !w_step_ok) begin
                r_point_x  <= '0;
                r_point_y  <= '0;
                r_is_last  <= 1'b0;
                r_past_end <= 1'b1;
            end else begin
                r_point_x  <= w_point_x;
                r_point_y  <= w_point_y;
                r_is_last  <= !i_restart && (w_cnt_inc == LAST_INDEX);
                r_past_end <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_point_x   = r_point_x;
    assign o_point_y   = r_point_y;
    assign o_is_last   = r_is_last;
    assign o_past_end  = r_past_end;

    `CBFD_ASSERT_SAME(a_cnt_range, i_clk, i_rst_n, 1'b1, r_step_cnt <= PAST_MARK)
    `CBFD_ASSERT_NEXT(a_restart_zero, i_clk, i_rst_n, w_accept && i_restart, r_step_cnt == '0)
    `CBFD_ASSERT_SAME(a_past_zero, i_clk, i_rst_n, r_out_valid && r_past_end,
        r_point_x == '0 && r_point_y == '0 && !r_is_last)
    `CBFD_ASSERT_SAME(a_last_cnt, i_clk, i_rst_n, r_out_valid && r_is_last,
        r_step_cnt == LAST_INDEX)
    `CBFD_ASSERT_NEXT(a_step_inc, i_clk, i_rst_n, w_ctrl.advance,
        r_step_cnt == $past(w_cnt_inc))

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the cubic Bezier forward-difference generator.
// Drives restart and step words, predicts every curve point in fixed point and checks it.
// Depends on cbfd_pkg and cubic_bezier_forward_difference_top.
module testbench;
    import cbfd_pkg::*;

    localparam int     CTRL_REGS    = REG_END_Y + 1;
    localparam int     HOLD_CYCLES  = 300;
    localparam int     CYCLE_LIMIT  = 400000;
    localparam int     RANDOM_ITEMS = 1250;
    localparam t_point PT_MAX       = t_point'((1 << (PT_W - 1)) - 1);
    localparam t_point PT_MIN       = t_point'(-(1 << (PT_W - 1)));

    typedef struct packed {
        t_state pos;
        t_state d1;
        t_state d2;
        t_state d3;
    } fd_axis_t;

    typedef struct packed {
        t_point x;
        t_point y;
        logic   last;
        logic   past;
    } curve_point_t;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [PT_W-1:0]      i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic                 i_restart  = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic signed [PT_W-1:0] o_point_x;
    logic signed [PT_W-1:0] o_point_y;
    logic                 o_is_last;
    logic                 o_past_end;

    cubic_bezier_forward_difference_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_restart   (i_restart),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_point_x   (o_point_x),
        .o_point_y   (o_point_y),
        .o_is_last   (o_is_last),
        .o_past_end  (o_past_end)
    );

    t_point          ctrl_mirror [CTRL_REGS];
    t_point          next_ctrl [CTRL_REGS];
    fd_axis_t        curve_x;
    fd_axis_t        curve_y;
    logic [CNT_W-1:0] point_index = PAST_MARK;

    bit              pending_restart [$];
    curve_point_t    expected_points [$];
    int              queued_count   = 0;
    int              accepted_count = 0;
    int              fail_count     = 0;
    int              cycle_count    = 0;
    bit              send_idle_on   = 1'b0;
    bit              recv_idle_on   = 1'b0;
    int              send_wait      = 0;
    int              recv_wait      = 0;
    int              hold_req       = 0;
    int              hold_seen      = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    function automatic fd_axis_t load_axis_diffs(t_point p0, t_point p1, t_point p2,
                                                 t_point p3);
        t_state   s0, s1, s2, s3, a, b, c;
        fd_axis_t r;
        s0 = p0;
        s1 = p1;
        s2 = p2;
        s3 = p3;
        a = -s0 + 3 * s1 - 3 * s2 + s3;
        b = 3 * s0 - 6 * s1 + 3 * s2;
        c = -3 * s0 + 3 * s1;
        r.pos = s0 <<< FRAC_BITS;
        r.d1  = (c <<< (2 * STEP_SHIFT)) + (b <<< STEP_SHIFT) + a;
        r.d2  = ((2 * b) <<< STEP_SHIFT) + 6 * a;
        r.d3  = 6 * a;
        return r;
    endfunction

    function automatic fd_axis_t step_axis_diffs(fd_axis_t f);
        f.pos = f.pos + f.d1;
        f.d1  = f.d1 + f.d2;
        f.d2  = f.d2 + f.d3;
        return f;
    endfunction

    function automatic t_point round_to_pixel(t_state v);
        t_state q;
        q = (v + (t_state'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        return q[PT_W-1:0];
    endfunction

    function automatic void advance_curve(logic restart);
        curve_point_t pt;
        pt = '0;
        if (restart) begin
            curve_x = load_axis_diffs(ctrl_mirror[REG_START_X], ctrl_mirror[REG_PULL_ONE_X],
                                      ctrl_mirror[REG_PULL_TWO_X], ctrl_mirror[REG_END_X]);
            curve_y = load_axis_diffs(ctrl_mirror[REG_START_Y], ctrl_mirror[REG_PULL_ONE_Y],
                                      ctrl_mirror[REG_PULL_TWO_Y], ctrl_mirror[REG_END_Y]);
            point_index = '0;
        end else if (point_index >= LAST_INDEX) begin
            pt.past = 1'b1;
            expected_points.push_back(pt);
            return;
        end else begin
            curve_x = step_axis_diffs(curve_x);
            curve_y = step_axis_diffs(curve_y);
            point_index = point_index + 1'b1;
        end
        pt.x    = round_to_pixel(curve_x.pos);
        pt.y    = round_to_pixel(curve_y.pos);
        pt.last = (point_index == LAST_INDEX);
        expected_points.push_back(pt);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                advance_curve(i_restart);
                accepted_count++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (send_wait > 0) begin
                    send_wait--;
                    i_in_valid <= 1'b0;
                end else if (pending_restart.size() > 0) begin
                    i_in_valid <= 1'b1;
                    i_restart  <= pending_restart.pop_front();
                    send_wait = send_idle_on ? $urandom_range(0, 12) : 0;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        curve_point_t want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_points.size() == 0) begin
                    $error("point word with no expectation waiting");
                    fail_count++;
                end else begin
                    want = expected_points.pop_front();
                    if (o_point_x !== want.x) begin
                        $error("point_x: expected %0d, actual %0d", want.x, o_point_x);
                        fail_count++;
                    end
                    if (o_point_y !== want.y) begin
                        $error("point_y: expected %0d, actual %0d", want.y, o_point_y);
                        fail_count++;
                    end
                    if (o_is_last !== want.last) begin
                        $error("is_last: expected %0d, actual %0d", want.last, o_is_last);
                        fail_count++;
                    end
                    if (o_past_end !== want.past) begin
                        $error("past_end: expected %0d, actual %0d", want.past, o_past_end);
                        fail_count++;
                    end
                end
                recv_wait = recv_idle_on ? $urandom_range(0, 12) : 0;
            end
            if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                recv_wait = HOLD_CYCLES;
            end
            if (recv_wait > 0) begin
                recv_wait--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic queue_word(bit restart);
        pending_restart.push_back(restart);
        queued_count++;
    endtask

    task automatic queue_steps(int n);
        repeat (n) queue_word(1'b0);
    endtask

    task automatic drain();
        while (accepted_count != queued_count || expected_points.size() > 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apply_controls();
        int i;
        for (i = 0; i < CTRL_REGS; i++) begin
            @(posedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= CFG_IDX_W'(i);
            i_cfg_data <= next_ctrl[i];
            ctrl_mirror[i] = next_ctrl[i];
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic pick_controls(bit corners);
        int i;
        for (i = 0; i < CTRL_REGS; i++)
            next_ctrl[i] = corners ? ($urandom_range(0, 1) ? PT_MAX : PT_MIN)
                                   : t_point'($urandom_range(0, (1 << PT_W) - 1));
    endtask

    initial begin
        int i;
        int n;
        int random_items;
        for (i = 0; i < CTRL_REGS; i++)
            ctrl_mirror[i] = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Steps before any restart report past end, then a short curve on zero controls.
        queue_steps(2);
        queue_word(1'b1);
        queue_steps(2);
        drain();

        for (i = 0; i < CTRL_REGS; i++)
            next_ctrl[i] = ((i + i / 2) % 2) ? PT_MAX : PT_MIN;
        apply_controls();
        queue_word(1'b1);
        queue_steps(4);
        drain();

        // New controls must not disturb the curve in progress until the next restart.
        for (i = 0; i < CTRL_REGS; i++)
            next_ctrl[i] = PT_MAX;
        apply_controls();
        queue_steps(2);
        queue_word(1'b1);
        queue_steps(2);
        drain();

        for (i = 0; i < CTRL_REGS; i++)
            next_ctrl[i] = PT_MIN;
        apply_controls();
        queue_word(1'b1);
        queue_steps(2);
        queue_word(1'b1);
        queue_word(1'b0);
        drain();

        // One full curve to the last point and beyond, with a long output stall.
        send_idle_on = 1'b0;
        recv_idle_on = 1'b1;
        pick_controls($urandom_range(0, 1));
        apply_controls();
        queue_word(1'b1);
        queue_steps(LAST_INDEX + 3);
        random_items = LAST_INDEX + 4;
        hold_req++;
        drain();

        while (random_items < RANDOM_ITEMS) begin
            send_idle_on = ($urandom_range(0, 3) != 0);
            recv_idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 2) != 0) begin
                pick_controls($urandom_range(0, 3) == 0);
                apply_controls();
            end
            if ($urandom_range(0, 4) == 0) begin
                n = $urandom_range(1, 6);
                queue_steps(n);
                random_items += n;
            end
            repeat ($urandom_range(1, 3)) begin
                n = $urandom_range(0, 40);
                queue_word(1'b1);
                queue_steps(n);
                random_items += n + 1;
            end
            drain();
        end

        if (fail_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

FILE: files.f
+incdir+src
src/cbfd_pkg.sv
src/cbfd_cfg_regs.sv
src/cbfd_axis.sv
src/cubic_bezier_forward_difference_top.sv
tb/testbench.sv
